>>> sv/blle_pkg.sv
package blle_pkg;

    localparam int CAPACITY = 16;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int LINK_W   = SLOT_W + 1;
    localparam int CTR_W    = $clog2(CAPACITY + 1);
    localparam int ACT_W    = 3;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;

    typedef logic [ACT_W-1:0]         t_action;
    typedef logic signed [VAL_W-1:0]  t_value;
    typedef logic [STAT_W-1:0]        t_status;
    typedef logic [POS_W-1:0]         t_pos;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [SLOT_W-1:0]        t_slot;
    typedef logic [LINK_W-1:0]        t_link;
    typedef logic [CTR_W-1:0]         t_ctr;

    localparam t_link NULL_LINK = LINK_W'(CAPACITY);

    localparam t_action ACT_INS_HEAD  = 3'd0;
    localparam t_action ACT_INS_TAIL  = 3'd1;
    localparam t_action ACT_INS_AFTER = 3'd2;
    localparam t_action ACT_INS_SORT  = 3'd3;
    localparam t_action ACT_REMOVE    = 3'd4;
    localparam t_action ACT_SEARCH    = 3'd5;

    localparam t_status ST_DONE      = 2'd0;
    localparam t_status ST_NOT_FOUND = 2'd1;
    localparam t_status ST_FULL      = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

    typedef struct packed {
        t_slot  rd_addr;
        logic   val_we;
        logic   lnk_we;
        t_slot  wr_addr;
        t_value wr_val;
        t_link  wr_lnk;
    } t_pool_req;

    typedef struct packed {
        t_value val;
        t_link  link;
    } t_pool_rsp;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_cmp_res;

endpackage

>>> sv/blle_req_if.sv
interface blle_req_if;
    logic                 valid;
    logic                 ready;
    blle_pkg::t_action    action;
    blle_pkg::t_value     item_value;
    blle_pkg::t_value     reference_value;

    modport source (output valid, output action, output item_value,
                    output reference_value, input ready);
    modport sink   (input valid, input action, input item_value,
                    input reference_value, output ready);
endinterface

>>> sv/blle_rsp_if.sv
interface blle_rsp_if;
    logic                 valid;
    logic                 ready;
    blle_pkg::t_status    result_status;
    blle_pkg::t_pos       item_position;
    blle_pkg::t_cnt       entry_count;

    modport source (output valid, output result_status, output item_position,
                    output entry_count, input ready);
    modport sink   (input valid, input result_status, input item_position,
                    input entry_count, output ready);
endinterface

>>> sv/blle_cmp.sv
module blle_cmp (
    input  blle_pkg::t_value   i_lhs,
    input  blle_pkg::t_value   i_rhs,
    output blle_pkg::t_cmp_res o_res
);
    import blle_pkg::*;

    assign o_res.eq = (i_lhs == i_rhs);
    assign o_res.lt = ($signed(i_lhs) < $signed(i_rhs));

endmodule

>>> sv/blle_pool.sv
module blle_pool (
    input  logic                i_clk,
    input  blle_pkg::t_pool_req i_req,
    output blle_pkg::t_pool_rsp o_rsp
);
    import blle_pkg::*;

    t_value r_val_mem [CAPACITY];
    t_link  r_lnk_mem [CAPACITY];
    t_value r_q_val;
    t_link  r_q_link;

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_val_mem[i_req.wr_addr] <= i_req.wr_val;
        end
        if (i_req.lnk_we) begin
            r_lnk_mem[i_req.wr_addr] <= i_req.wr_lnk;
        end
        r_q_val  <= r_val_mem[i_req.rd_addr];
        r_q_link <= r_lnk_mem[i_req.rd_addr];
    end

    assign o_rsp.val  = r_q_val;
    assign o_rsp.link = r_q_link;

endmodule

>>> sv/blle_seq.sv
module blle_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    blle_req_if.sink            i_req,
    blle_rsp_if.source          o_rsp,
    output blle_pkg::t_pool_req o_pool,
    input  blle_pkg::t_pool_rsp i_pool
);
    import blle_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_WALK    = 3'd1;
    localparam logic [2:0] S_WR_NEW  = 3'd2;
    localparam logic [2:0] S_WR_PREV = 3'd3;
    localparam logic [2:0] S_UNLINK  = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CAPACITY-1:0] r_used, n_used;
    t_link         r_first, n_first;
    t_ctr          r_cnt, n_cnt;
    logic          r_o_valid, n_o_valid;
    t_action       r_act, n_act;
    t_value        r_val, n_val;
    t_value        r_ref, n_ref;
    t_slot         r_slot, n_slot;
    t_link         r_prev, n_prev;
    t_slot         r_cur, n_cur;
    t_slot         r_k, n_k;
    t_link         r_newlink, n_newlink;
    t_slot         r_pos, n_pos;
    t_status       r_status, n_status;
    t_status       r_o_status, n_o_status;
    t_pos          r_o_pos, n_o_pos;
    t_cnt          r_o_cnt, n_o_cnt;

    t_value        w_operand;
    t_cmp_res      w_cmp;
    t_slot         w_free;
    logic          w_full;
    logic          w_empty;
    logic          w_null;
    logic          w_brk_sort;
    t_link         w_cur_link;
    t_slot         w_pos_next;

    // the shared compare unit sees each entry as it is read
    assign w_operand = (r_act == ACT_INS_AFTER) ? r_ref : r_val;

    blle_cmp u_cmp (
        .i_lhs (i_pool.val),
        .i_rhs (w_operand),
        .o_res (w_cmp)
    );

    // lowest free slot
    always_comb begin
        w_free = '0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                w_free = SLOT_W'(i);
            end
        end
    end

    assign w_full     = &r_used;
    assign w_empty    = (r_first == NULL_LINK);
    assign w_null     = (i_pool.link == NULL_LINK);
    assign w_cur_link = {1'b0, r_cur};
    assign w_pos_next = r_k + 1'b1;
    assign w_brk_sort = (r_k == '0) ? (!w_cmp.lt && !w_cmp.eq) : !w_cmp.lt;

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.result_status = r_o_status;
    assign o_rsp.item_position = r_o_pos;
    assign o_rsp.entry_count   = r_o_cnt;

    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_first    = r_first;
        n_cnt      = r_cnt;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_act      = r_act;
        n_val      = r_val;
        n_ref      = r_ref;
        n_slot     = r_slot;
        n_prev     = r_prev;
        n_cur      = r_cur;
        n_k        = r_k;
        n_newlink  = r_newlink;
        n_pos      = r_pos;
        n_status   = r_status;
        n_o_status = r_o_status;
        n_o_pos    = r_o_pos;
        n_o_cnt    = r_o_cnt;

        o_pool         = '0;
        o_pool.rd_addr = (r_state == S_IDLE) ? r_first[SLOT_W-1:0]
                                             : i_pool.link[SLOT_W-1:0];
        o_pool.wr_addr = r_slot;
        o_pool.wr_val  = r_val;
        o_pool.wr_lnk  = r_newlink;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_act     = i_req.action;
                    n_val     = i_req.item_value;
                    n_ref     = i_req.reference_value;
                    n_slot    = w_free;
                    n_prev    = NULL_LINK;
                    n_cur     = r_first[SLOT_W-1:0];
                    n_k       = '0;
                    n_pos     = '0;
                    n_status  = ST_DONE;
                    n_newlink = r_first;
                    unique case (i_req.action) inside
                        ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_AFTER, ACT_INS_SORT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                                n_state  = S_DONE;
                            end else if (i_req.action == ACT_INS_HEAD || w_empty) begin
                                n_state = S_WR_NEW;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        ACT_REMOVE, ACT_SEARCH: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK: begin
                // continue by default: step to the successor
                n_prev = w_cur_link;
                n_cur  = i_pool.link[SLOT_W-1:0];
                n_k    = w_pos_next;
                unique case (r_act) inside
                    ACT_INS_TAIL, ACT_INS_AFTER: begin
                        if (w_null || (r_act == ACT_INS_AFTER && w_cmp.eq)) begin
                            n_newlink = i_pool.link;
                            n_pos     = w_pos_next;
                            n_state   = S_WR_NEW;
                        end
                    end
                    ACT_INS_SORT: begin
                        if (w_brk_sort) begin
                            // insert in front of the current entry
                            n_prev    = r_prev;
                            n_newlink = w_cur_link;
                            n_pos     = r_k;
                            n_state   = S_WR_NEW;
                        end else if (w_null) begin
                            n_newlink = i_pool.link;
                            n_pos     = w_pos_next;
                            n_state   = S_WR_NEW;
                        end
                    end
                    ACT_REMOVE, ACT_SEARCH: begin
                        if (w_cmp.eq) begin
                            n_prev    = r_prev;
                            n_cur     = r_cur;
                            n_pos     = r_k;
                            n_newlink = i_pool.link;
                            n_state   = (r_act == ACT_REMOVE) ? S_UNLINK : S_DONE;
                        end else if (w_null) begin
                            n_status = ST_NOT_FOUND;
                            n_pos    = '0;
                            n_state  = S_DONE;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_WR_NEW: begin
                o_pool.val_we  = 1'b1;
                o_pool.lnk_we  = 1'b1;
                n_used[r_slot] = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_prev == NULL_LINK) begin
                    n_first = {1'b0, r_slot};
                    n_state = S_DONE;
                end else begin
                    n_state = S_WR_PREV;
                end
            end
            S_WR_PREV: begin
                o_pool.lnk_we  = 1'b1;
                o_pool.wr_addr = r_prev[SLOT_W-1:0];
                o_pool.wr_lnk  = {1'b0, r_slot};
                n_state        = S_DONE;
            end
            S_UNLINK: begin
                if (r_prev == NULL_LINK) begin
                    n_first = r_newlink;
                end else begin
                    o_pool.lnk_we  = 1'b1;
                    o_pool.wr_addr = r_prev[SLOT_W-1:0];
                end
                n_used[r_cur] = 1'b0;
                n_cnt         = r_cnt - 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_pos    = POS_W'(r_pos);
                    n_o_cnt    = CNT_W'(r_cnt);
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_first   <= NULL_LINK;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_first   <= n_first;
            r_cnt     <= n_cnt;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act      <= n_act;
        r_val      <= n_val;
        r_ref      <= n_ref;
        r_slot     <= n_slot;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
        r_k        <= n_k;
        r_newlink  <= n_newlink;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_pos    <= n_o_pos;
        r_o_cnt    <= n_o_cnt;
    end

endmodule

>>> sv/bounded_linked_list_engine_core.sv
// bounded linked list engine
// i_req carries one request: action, item_value, reference_value; it is taken
// when valid and ready are both high. o_rsp returns exactly one response per
// request: result_status, item_position and entry_count after the operation.
// the list lives in a pool of 16 slots; each slot holds a value and a link
// in a registered-read memory, and the walk reads one entry per cycle
// through a single shared comparator.
// ready is high only while the sequencer is idle, so one request is in
// flight at a time. from accept, the sequencer goes through these states:
//   full, empty, unused action: straight to the done state
//   head insert or insert into an empty list: write the new entry, then done
//   walking requests: a walk state per entry visited (1 to 16); inserts then
//   write the new entry and any predecessor link, a removal unlinks, then done.
// the response sits in an output register; while the receiver stalls it
// holds, and the engine finishes the next request and waits with it.
// reset clears the list (no entries, all slots free) and drops any response.
module bounded_linked_list_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    blle_req_if.sink    i_req,
    blle_rsp_if.source  o_rsp
);
    import blle_pkg::*;

    t_pool_req w_pool_req;
    t_pool_rsp w_pool_rsp;

    blle_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_pool  (w_pool_req),
        .i_pool  (w_pool_rsp)
    );

    blle_pool u_pool (
        .i_clk (i_clk),
        .i_req (w_pool_req),
        .o_rsp (w_pool_rsp)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("engine still ready after taking a request");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count beyond pool size");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.result_status == ST_FULL)
            |-> (o_rsp.entry_count == CNT_W'(CAPACITY) && o_rsp.item_position == '0))
        else $error("pool full reported with free slots");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.result_status == ST_EMPTY)
            |-> (o_rsp.entry_count == '0 && o_rsp.item_position == '0))
        else $error("list empty reported with entries");
`endif

endmodule
